### hdl/cpe_pkg.sv
// Shared types and constants for the complex polynomial evaluator.
// No dependencies; used by cpe_cell and complex_polynomial_evaluator.
`timescale 1ns / 1ps
`default_nettype none

package cpe_pkg;

  // Data word width of every real or imaginary part (Q format, signed).
  localparam int unsigned WordW = 32;
  // Number of coefficient registers (z^0 .. z^6).
  localparam int unsigned NumCoef = 7;
  // Configuration index width (degree register plus coefficients).
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CoefW = 2 * WordW;
  localparam int unsigned DegW = 3;

  // Configuration register map.
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEGREE = 3'd0,
    REG_COEF0  = 3'd1,
    REG_COEF1  = 3'd2,
    REG_COEF2  = 3'd3,
    REG_COEF3  = 3'd4,
    REG_COEF4  = 3'd5,
    REG_COEF5  = 3'd6,
    REG_COEF6  = 3'd7
  } cfg_reg_e;

  // One item in flight along the cell chain: point, accumulator, overflow flag.
  typedef struct packed {
    logic signed [WordW-1:0] zr;
    logic signed [WordW-1:0] zi;
    logic signed [WordW-1:0] ar;
    logic signed [WordW-1:0] ai;
    logic                    ovf;
  } cpe_data_t;

endpackage

`default_nettype wire

### hdl/cpe_cell.sv
// One Horner step cell: acc = sat(sat(floor(acc*z)) + coef), three register stages.
// Depends on cpe_pkg (cpe_data_t, WordW, CoefW).
`timescale 1ns / 1ps
`default_nettype none

module cpe_cell #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          active_i,
  input  wire logic [cpe_pkg::CoefW-1:0]     coef_i,
  input  wire logic                          valid_i,
  input  wire cpe_pkg::cpe_data_t            data_i,
  output logic                               ready_o,
  output logic                               valid_o,
  output cpe_pkg::cpe_data_t                 data_o,
  input  wire logic                          ready_i
);

  localparam int W  = cpe_pkg::WordW;
  localparam int PW = 2 * W;      // product width
  localparam int SW = 2 * W + 1;  // product sum width

  // Saturate a product sum (already shifted) to one word; MSB of result is the flag.
  function automatic logic [W:0] sat_wide(input logic signed [SW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    logic [W:0] r;
    hi_ones  = &v[SW-1:W-1];
    hi_zeros = ~|v[SW-1:W-1];
    if (hi_ones || hi_zeros) begin
      r = {1'b0, v[W-1:0]};
    end else if (v[SW-1]) begin
      r = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a word plus word sum to one word.
  function automatic logic [W:0] sat_sum(input logic signed [W:0] v);
    logic [W:0] r;
    if (v[W] == v[W-1]) begin
      r = {1'b0, v[W-1:0]};
    end else if (v[W]) begin
      r = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  // Stage handshake
  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic rdy1, rdy2, rdy3;

  // Stage 1: partial products
  logic signed [PW-1:0] prr_q, pii_q, pri_q, pir_q;
  logic signed [PW-1:0] prr_d, pii_d, pri_d, pir_d;
  cpe_pkg::cpe_data_t   d1_q;

  // Stage 2: floored, saturated product
  logic signed [SW-1:0] sum_re, sum_im, sh_re, sh_im;
  logic [W:0]           satp_re, satp_im;
  logic signed [W-1:0]  pr_q, pi_q;
  cpe_pkg::cpe_data_t   d2_q, d2_d;

  // Stage 3: coefficient add
  logic signed [W:0]    acc_re, acc_im;
  logic [W:0]           sata_re, sata_im;
  cpe_pkg::cpe_data_t   d3_q, d3_d;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    v1_d = rdy1 ? valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_comb begin
    prr_d = data_i.ar * data_i.zr;
    pii_d = data_i.ai * data_i.zi;
    pri_d = data_i.ar * data_i.zi;
    pir_d = data_i.ai * data_i.zr;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      prr_q <= prr_d;
      pii_q <= pii_d;
      pri_q <= pri_d;
      pir_q <= pir_d;
      d1_q  <= data_i;
    end
  end

  // Exact 65-bit sums, arithmetic shift gives floor division.
  always_comb begin
    sum_re  = {prr_q[PW-1], prr_q} - {pii_q[PW-1], pii_q};
    sum_im  = {pri_q[PW-1], pri_q} + {pir_q[PW-1], pir_q};
    sh_re   = sum_re >>> FRAC_BITS;
    sh_im   = sum_im >>> FRAC_BITS;
    satp_re = sat_wide(sh_re);
    satp_im = sat_wide(sh_im);
    d2_d     = d1_q;
    d2_d.ovf = d1_q.ovf | (active_i & (satp_re[W] | satp_im[W]));
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pr_q <= satp_re[W-1:0];
      pi_q <= satp_im[W-1:0];
      d2_q <= d2_d;
    end
  end

  always_comb begin
    acc_re  = {pr_q[W-1], pr_q} + {coef_i[2*W-1], coef_i[2*W-1:W]};
    acc_im  = {pi_q[W-1], pi_q} + {coef_i[W-1], coef_i[W-1:0]};
    sata_re = sat_sum(acc_re);
    sata_im = sat_sum(acc_im);
    d3_d    = d2_q;
    if (active_i) begin
      d3_d.ar  = sata_re[W-1:0];
      d3_d.ai  = sata_im[W-1:0];
      d3_d.ovf = d2_q.ovf | sata_re[W] | sata_im[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      d3_q <= d3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = d3_q;

endmodule

`default_nettype wire

### hdl/complex_polynomial_evaluator.sv
// Top level of the complex polynomial evaluator: register file and Horner cell chain.
// Depends on cpe_pkg and cpe_cell.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates p(z) = sum coef_k * z^k, k = 0..degree, at one complex point per
// transfer, by Horner's rule in signed fixed point with FRAC_BITS fraction bits.
// Throughput is one point per clock while the output is not held off; the
// chain has MAX_DEGREE cells, each holding three stages (four 32x32
// multipliers, floor and saturate of the product sum, coefficient add and
// saturate). Steps above the configured degree pass the accumulator through,
// so latency does not depend on the degree. Each product is floored to
// FRAC_BITS fraction bits; every product and sum saturates to 32 bits and sets
// overflow_o. Coefficients pack the real part in bits 63:32 and the imaginary
// part in 31:0. A degree above MAX_DEGREE acts as MAX_DEGREE. Configuration
// writes are always accepted and must be made while no point is in flight.
module complex_polynomial_evaluator #(
  parameter int MAX_DEGREE = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cpe_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [cpe_pkg::CoefW-1:0]          cfg_data_i,
  // point input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [cpe_pkg::WordW-1:0]   point_re_i,
  input  wire logic signed [cpe_pkg::WordW-1:0]   point_im_i,
  // result output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [cpe_pkg::WordW-1:0]        value_re_o,
  output logic signed [cpe_pkg::WordW-1:0]        value_im_o,
  output logic                                    overflow_o
);

  localparam int W = cpe_pkg::WordW;

  // Configuration registers
  logic [cpe_pkg::DegW-1:0]  degree_q;
  logic [cpe_pkg::CoefW-1:0] coef_q [cpe_pkg::NumCoef];
  logic [cpe_pkg::DegW-1:0]  deg_eff;

  // Cell chain links; link 0 is the input, link MAX_DEGREE the output
  logic               valid_c [MAX_DEGREE+1];
  logic               ready_c [MAX_DEGREE+1];
  cpe_pkg::cpe_data_t data_c  [MAX_DEGREE+1];

  assign cfg_ready_o = 1'b1;

  // Register writes; index 0 is the degree, index k+1 is coef_k.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      for (int k = 0; k < cpe_pkg::NumCoef; k++) begin
        coef_q[k] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == cpe_pkg::REG_DEGREE) begin
        degree_q <= cfg_data_i[cpe_pkg::DegW-1:0];
      end else begin
        coef_q[cfg_index_i - cpe_pkg::REG_COEF0] <= cfg_data_i;
      end
    end
  end

  // Clamp degree to the number of cells built.
  assign deg_eff = (degree_q > cpe_pkg::DegW'(MAX_DEGREE)) ? cpe_pkg::DegW'(MAX_DEGREE)
                                                          : degree_q;

  // Accumulator enters the chain holding the top coefficient.
  // Field order: zr, zi, ar, ai, ovf.
  assign valid_c[0] = in_valid_i;
  assign data_c[0]  = {point_re_i, point_im_i,
                       coef_q[deg_eff][2*W-1:W], coef_q[deg_eff][W-1:0], 1'b0};
  assign in_ready_o = ready_c[0];

  // Cell j applies coefficient MAX_DEGREE-1-j; it is active only below the degree.
  for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cell
    localparam int Idx = MAX_DEGREE - 1 - j;
    logic active;
    assign active = (cpe_pkg::DegW'(Idx) < deg_eff);

    cpe_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active),
      .coef_i   (coef_q[cpe_pkg::DegW'(Idx)]),
      .valid_i  (valid_c[j]),
      .data_i   (data_c[j]),
      .ready_o  (ready_c[j]),
      .valid_o  (valid_c[j+1]),
      .data_o   (data_c[j+1]),
      .ready_i  (ready_c[j+1])
    );
  end

  // Last cell's final stage is the output register.
  assign ready_c[MAX_DEGREE] = out_ready_i;
  assign out_valid_o = valid_c[MAX_DEGREE];
  assign value_re_o  = data_c[MAX_DEGREE].ar;
  assign value_im_o  = data_c[MAX_DEGREE].ai;
  assign overflow_o  = data_c[MAX_DEGREE].ovf;

  // With degree zero every cell passes through: no overflow, result is coef_0.
  a_deg0_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (deg_eff == '0)) |-> !overflow_o)
    else $error("overflow flagged at degree zero");

  a_deg0_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (deg_eff == '0)) |->
      ((value_re_o == coef_q[0][2*W-1:W]) && (value_im_o == coef_q[0][W-1:0])))
    else $error("degree zero result differs from constant term");

  // The input stalls only when the whole chain is full behind a held result.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output side is free");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for complex_polynomial_evaluator: a fixed-point Horner predictor,
// valid/ready drivers with random idling, back pressure and register reloads.
// Depends on cpe_pkg and the evaluator RTL only.

module testbench;

  localparam int MaxDeg    = 6;
  localparam int FracBits  = 16;
  // Chain of MAX_DEGREE cells, three stages each; fixed whatever the degree.
  localparam int PipeDepth = 3 * MaxDeg;
  // Percent of cycles in which either side idles.
  localparam int IdlePct   = 11;

  localparam logic signed [65:0] WordMax = 66'sd2147483647;
  localparam logic signed [65:0] WordMin = -66'sd2147483648;

  typedef logic signed [cpe_pkg::WordW-1:0] word_t;

  // One polynomial value as the block reports it.
  typedef struct {
    word_t re;
    word_t im;
    logic  ovf;
  } poly_value_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [cpe_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [cpe_pkg::CoefW-1:0]   cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  word_t                       point_re_i  = '0;
  word_t                       point_im_i  = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  word_t                       value_re_o;
  word_t                       value_im_o;
  logic                        overflow_o;

  complex_polynomial_evaluator #(
    .MAX_DEGREE(MaxDeg),
    .FRAC_BITS (FracBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .point_re_i (point_re_i),
    .point_im_i (point_im_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_re_o (value_re_o),
    .value_im_o (value_im_o),
    .overflow_o (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the register file, updated on each config transfer.
  logic [cpe_pkg::DegW-1:0]  shadow_degree;
  logic [cpe_pkg::CoefW-1:0] shadow_coef  [cpe_pkg::NumCoef];
  // Coefficients a test lines up before calling load_poly.
  logic [cpe_pkg::CoefW-1:0] staged_coef  [cpe_pkg::NumCoef];

  poly_value_t predicted_values[$];

  bit quiet_mode   = 1'b0;  // no idling on either side while set
  int hold_request = 0;     // receiver hold-off length, picked up by the receiver
  int hold_left    = 0;

  int points_sent       = 0;
  int results_checked   = 0;
  int saturated_results = 0;
  int reg_writes        = 0;
  int mismatches        = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic word_t clamp_word(input logic signed [65:0] v, inout bit hit);
    if (v > WordMax) begin
      hit = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < WordMin) begin
      hit = 1'b1;
      return 32'h8000_0000;
    end
    return v[cpe_pkg::WordW-1:0];
  endfunction

  // Horner's rule from the top coefficient down. Products are exact in 66 bits,
  // floored by the arithmetic shift, then clamped; each coefficient add clamps too.
  function automatic poly_value_t horner_eval(input word_t zr_w, input word_t zi_w);
    logic signed [65:0] zr, zi, ar, ai, pr, pi;
    int                 d;
    bit                 hit;
    poly_value_t        res;
    zr  = zr_w;
    zi  = zi_w;
    hit = 1'b0;
    // a degree of 7 acts as the bound
    d   = (int'(shadow_degree) > MaxDeg) ? MaxDeg : int'(shadow_degree);
    ar  = $signed(shadow_coef[d][cpe_pkg::CoefW-1:cpe_pkg::WordW]);
    ai  = $signed(shadow_coef[d][cpe_pkg::WordW-1:0]);
    for (int k = d - 1; k >= 0; k--) begin
      pr = (ar * zr - ai * zi) >>> FracBits;
      pi = (ar * zi + ai * zr) >>> FracBits;
      ar = clamp_word(pr, hit);
      ai = clamp_word(pi, hit);
      ar = clamp_word(ar + $signed(shadow_coef[k][cpe_pkg::CoefW-1:cpe_pkg::WordW]), hit);
      ai = clamp_word(ai + $signed(shadow_coef[k][cpe_pkg::WordW-1:0]), hit);
    end
    res.re  = ar[cpe_pkg::WordW-1:0];
    res.im  = ai[cpe_pkg::WordW-1:0];
    res.ovf = hit;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int idle_gap();
    int n;
    n = 0;
    if (quiet_mode) return 0;
    while ($urandom_range(0, 99) < IdlePct) n++;
    return n;
  endfunction

  // Mostly values within +/- 2^span LSBs, with some full-range and corner values.
  function automatic word_t pick_word(input int span);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      default: return word_t'($urandom_range(0, (1 << (span + 1)) - 1)) - word_t'(1 << span);
    endcase
  endfunction

  task automatic stage_random_coefs(input int span);
    for (int k = 0; k < cpe_pkg::NumCoef; k++)
      staged_coef[k] = {pick_word(span), pick_word(span)};
  endtask

  task automatic clear_staged();
    for (int k = 0; k < cpe_pkg::NumCoef; k++) staged_coef[k] = '0;
  endtask

  // One point transfer. Valid stays high after the transfer; the next call
  // either swaps the payload in the same step or drops valid for a gap.
  task automatic push_point(input word_t re, input word_t im);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_re_i <= re;
    point_im_i <= im;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_values.push_back(horner_eval(re, im));
    points_sent++;
  endtask

  task automatic push_random_points(input int count, input int span);
    for (int n = 0; n < count; n++) push_point(pick_word(span), pick_word(span));
  endtask

  // Drop valid and wait until every predicted value has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_values.size() != 0);
  endtask

  task automatic write_reg(input cpe_pkg::cfg_reg_e idx,
                           input logic [cpe_pkg::CoefW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == cpe_pkg::REG_DEGREE) shadow_degree = data[cpe_pkg::DegW-1:0];
    else shadow_coef[int'(idx) - int'(cpe_pkg::REG_COEF0)] = data;
    reg_writes++;
  endtask

  // Reload the whole register file with the block idle. Upper bits of the
  // degree word are random; only the low bits should matter.
  task automatic load_poly(input logic [cpe_pkg::DegW-1:0] deg);
    logic [cpe_pkg::CoefW-1:0] deg_word;
    settle();
    deg_word                    = {$urandom(), $urandom()};
    deg_word[cpe_pkg::DegW-1:0] = deg;
    write_reg(cpe_pkg::REG_DEGREE, deg_word);
    for (int k = 0; k < cpe_pkg::NumCoef; k++)
      write_reg(cpe_pkg::cfg_reg_e'(int'(cpe_pkg::REG_COEF0) + k), staged_coef[k]);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // Random ready, or held low for a requested number of cycles.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet_mode || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : check_result
    poly_value_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_values.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: re=%h im=%h ovf=%b", value_re_o, value_im_o, overflow_o);
        mismatches++;
      end else begin
        want = predicted_values.pop_front();
        results_checked++;
        if (overflow_o === 1'b1) saturated_results++;
        if (value_re_o !== want.re || value_im_o !== want.im || overflow_o !== want.ovf) begin
          if (mismatches < 10)
            $display("mismatch at %0t: exp re=%h im=%h ovf=%b, got re=%h im=%h ovf=%b",
                     $realtime, want.re, want.im, want.ovf, value_re_o, value_im_o, overflow_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers straight out of reset: degree 0, all coefficients zero.
  task automatic test_reset_state();
    push_point(32'h7fff_ffff, 32'h8000_0000);
    push_point(32'h0001_0000, 32'hffff_0000);
  endtask

  task automatic test_directed();
    // Degree zero: coef_0 passes untouched, no overflow even at the rails.
    clear_staged();
    staged_coef[0] = {32'h8000_0000, 32'h7fff_ffff};
    staged_coef[1] = {32'h7fff_ffff, 32'h7fff_ffff};
    load_poly(3'd0);
    push_point(32'h7fff_ffff, 32'h7fff_ffff);
    push_point(32'h8000_0000, 32'h0000_0001);

    // p(z) = 0.5 z: negative half-LSB products must floor toward minus infinity.
    clear_staged();
    staged_coef[1] = {32'h0000_8000, 32'h0000_0000};
    load_poly(3'd1);
    push_point(32'hffff_ffff, 32'hffff_ffff);
    push_point(32'h0000_0001, 32'h0000_0001);
    push_point(32'h7fff_ffff, 32'h8000_0000);
    push_point(32'h0000_0003, 32'hffff_fffd);

    // Large coefficients: product saturation both ways, then add saturation.
    clear_staged();
    staged_coef[1] = {32'h7fff_ffff, 32'h7fff_ffff};
    staged_coef[0] = {32'h7fff_ffff, 32'h8000_0000};
    load_poly(3'd1);
    push_point(32'h7fff_ffff, 32'h7fff_ffff);
    push_point(32'h8000_0000, 32'h8000_0000);
    push_point(32'h8000_0000, 32'h7fff_ffff);
    push_point(32'h0001_0000, 32'h0000_0000);
    push_point(32'h0000_0000, 32'h0000_0000);

    // Degree 7 clamps to 6: p(z) = z^6 + small constant.
    clear_staged();
    staged_coef[6] = {32'h0001_0000, 32'h0000_0000};
    staged_coef[0] = {32'h0000_0100, 32'hffff_ff00};
    load_poly(3'd7);
    push_point(32'h0001_0000, 32'h0000_0000);
    push_point(32'h0000_0000, 32'h0001_0000);
    push_point(32'h0002_0000, 32'h0000_0000);
    push_point(32'h0008_0000, 32'h0000_0000);
    push_point(32'hffff_ffff, 32'h0000_0000);

    // Full degree with every coefficient at the negative rail.
    for (int k = 0; k < cpe_pkg::NumCoef; k++) staged_coef[k] = {32'h8000_0000, 32'h8000_0000};
    load_poly(3'd6);
    push_point(32'h8000_0000, 32'h8000_0000);
    push_point(32'hffff_0000, 32'h0000_0000);
  endtask

  // Bulk of the run: a series of register settings, each with a random stream.
  task automatic test_random_phases();
    logic [cpe_pkg::DegW-1:0] deg;
    int                       span;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       deg = 3'd6;
        1:       deg = 3'd0;
        2:       deg = 3'd7;
        default: deg = cpe_pkg::DegW'($urandom_range(0, 7));
      endcase
      if (p == 0) begin
        // full-range coefficients: mostly saturating paths
        for (int k = 0; k < cpe_pkg::NumCoef; k++) staged_coef[k] = {$urandom(), $urandom()};
      end else begin
        stage_random_coefs($urandom_range(14, 18));
      end
      load_poly(deg);
      // keep deep polynomials near the unit circle so results stay in range
      span = (deg >= 4) ? $urandom_range(14, 16) : $urandom_range(15, 18);
      push_random_points(130, span);
    end
  endtask

  // Receiver holds off long enough for the chain to fill and stall the input.
  task automatic test_back_pressure();
    stage_random_coefs(16);
    load_poly(cpe_pkg::DegW'($urandom_range(1, 6)));
    hold_request = 200;
    push_random_points(120, 16);
  endtask

  // Sender goes quiet until the block has drained, then resumes.
  task automatic test_drain_pause();
    stage_random_coefs(17);
    load_poly(cpe_pkg::DegW'($urandom_range(2, 7)));
    push_random_points(40, 16);
    settle();
    push_random_points(40, 16);
  endtask

  // Long stretch with both sides always ready: full-rate streaming.
  task automatic test_quiet_stream();
    stage_random_coefs(16);
    load_poly(cpe_pkg::DegW'($urandom_range(1, 6)));
    quiet_mode = 1'b1;
    push_random_points(150, 16);
    quiet_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    shadow_degree = '0;
    for (int k = 0; k < cpe_pkg::NumCoef; k++) shadow_coef[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_directed();
    test_random_phases();
    test_back_pressure();
    test_drain_pause();
    test_quiet_stream();

    settle();
    // extra cycles to catch stray results after the last expected one
    repeat (2 * PipeDepth) @(posedge clk_i);

    $display("run covered %0d points and %0d register transfers; %0d values checked, %0d saturated",
             points_sent, reg_writes, results_checked, saturated_results);
    if (predicted_values.size() != 0)
      $display("%0d predicted values never arrived", predicted_values.size());
    if (mismatches == 0 && predicted_values.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

### complex_polynomial_evaluator.f
hdl/cpe_pkg.sv
hdl/cpe_cell.sv
hdl/complex_polynomial_evaluator.sv
tb/testbench.sv
